[rtl/core/lrukv_pkg.sv]
package lrukv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam int PER_W = 16;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 16;

  localparam logic [0:0] REG_CAPACITY = 1'b0;
  localparam logic [0:0] REG_PERIOD   = 1'b1;

  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming transaction and compare keys
    logic update;   // apply the put/get and the periodic eviction
  } lrukv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_get;
  } lrukv_stat_t;

endpackage

[rtl/core/lrukv_ctrl.sv]
module lrukv_ctrl
  import lrukv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output lrukv_cmd_t  cmd,
  input  lrukv_stat_t stat
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state == S_UPD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_upd_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.update) else $error("update did not follow capture");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.update)) else $error("capture and update together");
  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("busy longer than one cycle");
  a_stat_known: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !$isunknown(stat.is_get)) else $error("status unknown in update");

endmodule

[rtl/core/lrukv_dp.sv]
module lrukv_dp
  import lrukv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  lrukv_cmd_t               cmd,
  output lrukv_stat_t              stat,
  input  logic                     func,
  input  logic signed [KEY_W-1:0]  key,
  input  logic signed [VAL_W-1:0]  data_in,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic                     done,
  output logic                     found,
  output logic signed [VAL_W-1:0]  read_value
);

  logic [CAP_W-1:0] capacity;
  logic [PER_W-1:0] evict_period;
  logic [PER_W-1:0] item_count;

  logic               valid [ENTRIES];
  logic [KEY_W-1:0]   ekey  [ENTRIES];
  logic [VAL_W-1:0]   evalue[ENTRIES];
  logic [IDX_W-1:0]   rank  [ENTRIES];

  logic               r_func;
  logic [VAL_W-1:0]   r_data;
  logic [KEY_W-1:0]   r_key;
  logic               r_hit;
  logic [IDX_W-1:0]   r_idx;
  logic [CNT_W-1:0]   r_occ;

  assign stat.is_get = r_func;

  // Capture step: parallel compare and occupancy count.
  logic             hit_c;
  logic [IDX_W-1:0] idx_c;
  logic [CNT_W-1:0] occ_c;
  always_comb begin
    hit_c = 1'b0;
    idx_c = '0;
    occ_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i]) begin
        occ_c = occ_c + CNT_W'(1);
        if (ekey[i] == key) begin
          hit_c = 1'b1;
          idx_c = IDX_W'(i);
        end
      end
    end
  end

  // Update step: recency update, insertion and periodic eviction.
  logic [CNT_W-1:0] cap_eff;
  logic             ins_evict;
  logic [IDX_W-1:0] hit_rank;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] occ1;
  logic             per_evict;
  logic [PER_W:0]   cnt_inc;
  logic [PER_W-1:0] per_eff;
  logic             nv   [ENTRIES];
  logic [IDX_W-1:0] nr   [ENTRIES];
  logic [IDX_W-1:0] lru1;
  logic [IDX_W-1:0] lru2;

  always_comb begin
    if (capacity == '0) cap_eff = CNT_W'(1);
    else if (32'(capacity) > ENTRIES) cap_eff = CNT_W'(ENTRIES);
    else cap_eff = CNT_W'(capacity);
    hit_rank = rank[r_idx];
    ins_evict = !r_func && !r_hit && (r_occ >= cap_eff) && (r_occ != '0);
    lru1 = IDX_W'(r_occ - CNT_W'(1));
    per_eff = (evict_period == '0) ? PER_W'(1) : evict_period;
    cnt_inc = {1'b0, item_count} + (PER_W+1)'(1);
    per_evict = cnt_inc >= {1'b0, per_eff};
    // Stage A: eviction by insertion.
    for (int i = 0; i < ENTRIES; i++) begin
      nv[i] = valid[i];
      nr[i] = rank[i];
      if (ins_evict && valid[i] && rank[i] == lru1) begin
        nv[i] = 1'b0;
        nr[i] = '0;
      end
    end
    occ1 = ins_evict ? r_occ - CNT_W'(1) : r_occ;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!nv[i]) free_idx = IDX_W'(i);
    end
    // Stage B: touch or insert.
    if (r_hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (nv[i] && rank[i] < hit_rank) nr[i] = rank[i] + IDX_W'(1);
      end
      nr[r_idx] = '0;
    end else if (!r_func && occ1 < CNT_W'(ENTRIES)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (nv[i]) nr[i] = nr[i] + IDX_W'(1);
      end
      nv[free_idx] = 1'b1;
      nr[free_idx] = '0;
      occ1 = occ1 + CNT_W'(1);
    end
    // Stage C: periodic eviction.
    lru2 = IDX_W'(occ1 - CNT_W'(1));
    if (per_evict && occ1 != '0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (nv[i] && nr[i] == lru2) begin
          nv[i] = 1'b0;
          nr[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_func <= func;
      r_key  <= key;
      r_data <= data_in;
      r_hit  <= hit_c;
      r_idx  <= idx_c;
      r_occ  <= occ_c;
    end
    if (cmd.update) begin
      if (r_hit) begin
        if (!r_func) evalue[r_idx] <= r_data;
      end else if (!r_func && occ1 != CNT_W'(0)) begin
        ekey[free_idx]   <= r_key;
        evalue[free_idx] <= r_data;
      end
      read_value <= r_hit ? evalue[r_idx] : '1;
      found <= r_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(ENTRIES);
      evict_period <= '1;
      item_count <= '0;
      done <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
        rank[i] <= '0;
      end
    end else begin
      done <= cmd.update && r_func;
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) capacity <= cfg_data[CAP_W-1:0];
        else evict_period <= cfg_data[PER_W-1:0];
      end
      if (cmd.update) begin
        item_count <= per_evict ? '0 : cnt_inc[PER_W-1:0];
        for (int i = 0; i < ENTRIES; i++) begin
          valid[i] <= nv[i];
          rank[i] <= nr[i];
        end
      end
    end
  end

  a_done_only_get: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.update) && $past(r_func)) else $error("result without get");
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> read_value == '1) else $error("miss value wrong");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= 16'hFFFF) else $error("count out of range");

endmodule

[rtl/core/lru_key_value_cache.sv]
// LRU key/value cache, fully associative over ENTRIES slots.
// A get transaction's result strobes on done, registered by the update step after capture.
// A new transaction is not accepted while busy, which is high in the update step.
// The capture step compares all keys in parallel, the update step updates recency and evicts.
// Reset (synchronous, rst high) empties the table, clears the item count and
// restores capacity 16 and evict_period 65535. The receiver cannot stall results.
module lru_key_value_cache
  import lrukv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    func,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [VAL_W-1:0] data_in,
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    done,
  output logic                    found,
  output logic signed [VAL_W-1:0] read_value
);

  // The controller sequences capture and update; the datapath holds the table.
  lrukv_cmd_t  cmd;
  lrukv_stat_t stat;

  lrukv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
  );

  lrukv_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .func(func), .key(key), .data_in(data_in),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .found(found), .read_value(read_value)
  );

endmodule

[bench/tb_top.sv]
module tb_top;
  import lrukv_pkg::*;

  // Clock, reset and the ports of the cache.
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    func = FUNC_PUT;
  logic signed [KEY_W-1:0] key = '0;
  logic signed [VAL_W-1:0] data_in = '0;
  logic                    cfg_we = 1'b0;
  logic [0:0]              cfg_index = REG_CAPACITY;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    done;
  logic                    found;
  logic signed [VAL_W-1:0] read_value;

  lru_key_value_cache DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .key(key),
    .data_in(data_in), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .found(found), .read_value(read_value)
  );

  always #4 clk = ~clk;

  // One cache request as it waits in the driver queue.
  typedef struct {
    logic        op;
    logic [31:0] k;
    logic [31:0] v;
  } request_t;

  // One lookup answer the cache owes us.
  typedef struct {
    logic        hit;
    logic [31:0] val;
  } lookup_ans_t;

  request_t    pending_reqs[$];
  lookup_ans_t owed_answers[$];

  // Shadow copy of the cache table, kept in step with accepted transactions.
  logic        sh_valid[ENTRIES];
  logic [31:0] sh_key[ENTRIES];
  logic [31:0] sh_val[ENTRIES];
  int unsigned sh_rank[ENTRIES];
  int unsigned sh_count;
  int unsigned sh_cap;
  int unsigned sh_period;

  int  errors = 0;
  int  n_gets = 0;
  int  n_hits = 0;
  int  n_items = 0;
  int  idle_pct = 0;
  bit  hold_sender = 1'b0;
  int  quiet_cycles = 0;

  function automatic int unsigned occupancy();
    int unsigned n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) if (sh_valid[i]) n++;
    return n;
  endfunction

  // Promote an entry to most recent; younger entries age by one.
  function automatic void promote(int idx);
    int unsigned r;
    r = sh_rank[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (sh_valid[i] && sh_rank[i] < r) sh_rank[i]++;
    sh_rank[idx] = 0;
  endfunction

  // Drop the least recently used entry, if the table holds anything at all.
  function automatic void drop_oldest();
    int unsigned n;
    n = occupancy();
    if (n == 0) return;
    for (int i = 0; i < ENTRIES; i++)
      if (sh_valid[i] && sh_rank[i] == n - 1) begin
        sh_valid[i] = 1'b0;
        sh_rank[i] = 0;
        return;
      end
  endfunction

  // Apply one accepted request to the shadow table and queue any answer.
  function automatic void apply_request(request_t rq);
    int idx;
    int unsigned cap;
    int unsigned per;
    lookup_ans_t a;
    idx = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (idx < 0 && sh_valid[i] && sh_key[i] == rq.k) idx = i;
    if (rq.op == FUNC_PUT) begin
      if (idx >= 0) begin
        sh_val[idx] = rq.v;
        promote(idx);
      end else begin
        cap = (sh_cap == 0) ? 1 : sh_cap;
        if (cap > ENTRIES) cap = ENTRIES;
        if (occupancy() >= cap) drop_oldest();
        for (int i = 0; i < ENTRIES; i++)
          if (idx < 0 && !sh_valid[i]) begin
            for (int j = 0; j < ENTRIES; j++) if (sh_valid[j]) sh_rank[j]++;
            sh_valid[i] = 1'b1;
            sh_key[i] = rq.k;
            sh_val[i] = rq.v;
            sh_rank[i] = 0;
            idx = i;
          end
      end
    end else begin
      a.hit = (idx >= 0);
      a.val = (idx >= 0) ? sh_val[idx] : 32'hFFFF_FFFF;
      if (idx >= 0) promote(idx);
      owed_answers.insert(owed_answers.size(), a);
      n_gets++;
      if (idx >= 0) n_hits++;
    end
    // Periodic eviction counts puts and gets alike.
    per = (sh_period == 0) ? 1 : sh_period;
    if (sh_count + 1 >= per) begin
      drop_oldest();
      sh_count = 0;
    end else begin
      sh_count = sh_count + 1;
    end
  endfunction

  // Driver: takes the next request when the cache is free, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // The request on the ports is accepted at this edge.
      apply_request('{func, key, data_in});
      n_items++;
      if (pending_reqs.size() > 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
        func <= pending_reqs[0].op;
        key <= pending_reqs[0].k;
        data_in <= pending_reqs[0].v;
        void'(pending_reqs.pop_front());
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_reqs.size() > 0 && !hold_sender &&
                 $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      func <= pending_reqs[0].op;
      key <= pending_reqs[0].k;
      data_in <= pending_reqs[0].v;
      void'(pending_reqs.pop_front());
    end
  end

  // Monitor: every strobed answer must match the oldest one owed.
  always @(posedge clk) begin
    lookup_ans_t a;
    if (!rst && done) begin
      if (owed_answers.size() == 0) begin
        $display("%0t: unexpected answer found=%0b read_value=%h", $time, found, read_value);
        errors++;
      end else begin
        a = owed_answers.pop_front();
        if (found !== a.hit) begin
          $display("%0t: found expected %0b actual %0b", $time, a.hit, found);
          errors++;
        end
        if (read_value !== a.val) begin
          $display("%0t: read_value expected %h actual %h", $time, a.val, read_value);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction and no answer moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Small key pool so hits, updates and evictions happen often.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'h7FFF_FFFC + $urandom_range(3);
      default: return $urandom_range(23);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic op, logic [31:0] k, logic [31:0] v);
    request_t rq;
    rq = '{op, k, v};
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // Wait until the driver has sent everything and every answer is back,
  // then let the pipeline drain, since a put produces no strobe.
  task automatic drain();
    while (pending_reqs.size() > 0 || start || owed_answers.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only here, while the cache is idle.
  task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY) sh_cap = val & 16'h1F;
    else sh_period = val;
  endtask

  task automatic random_phase(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++)
      add_req($urandom_range(1) ? FUNC_GET : FUNC_PUT, pick_key(), pick_value());
    drain();
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i] = '0;
      sh_val[i] = '0;
      sh_rank[i] = 0;
    end
    sh_count = 0;
    sh_cap = 16;
    sh_period = 65535;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extreme keys and values, update of a present key,
    // hit and miss, and eviction when the table is full at capacity two.
    write_reg(REG_CAPACITY, 2);
    add_req(FUNC_GET, 32'h0, 32'h0);
    add_req(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    add_req(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    add_req(FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    add_req(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(FUNC_GET, 32'h7FFF_FFFF, 32'h0);
    add_req(FUNC_GET, 32'h8000_0000, 32'h0);
    add_req(FUNC_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
    add_req(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    drain();
    // Capacity zero acts as one; above the table size it acts as the size.
    write_reg(REG_CAPACITY, 0);
    add_req(FUNC_PUT, 32'h5, 32'h55);
    add_req(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    add_req(FUNC_GET, 32'h5, 32'h0);
    drain();
    write_reg(REG_CAPACITY, 31);
    // A period of zero forces an eviction after every transaction.
    write_reg(REG_PERIOD, 0);
    add_req(FUNC_PUT, 32'h1, 32'h11);
    add_req(FUNC_GET, 32'h1, 32'h0);
    add_req(FUNC_GET, 32'h1, 32'h0);
    drain();
    // Period lowered below the running count.
    write_reg(REG_PERIOD, 5);
    for (int i = 0; i < 4; i++) add_req(FUNC_PUT, i, i + 100);
    drain();
    write_reg(REG_PERIOD, 2);
    add_req(FUNC_GET, 32'h0, 32'h0);
    add_req(FUNC_GET, 32'h3, 32'h0);
    drain();

    // Random phases over several settings and idling patterns.
    write_reg(REG_PERIOD, 65535);
    write_reg(REG_CAPACITY, 16);
    random_phase(80, 0);
    write_reg(REG_CAPACITY, 4);
    write_reg(REG_PERIOD, 7);
    random_phase(80, 57);
    write_reg(REG_CAPACITY, 1);
    write_reg(REG_PERIOD, 1);
    random_phase(40, 37);
    write_reg(REG_CAPACITY, 9);
    write_reg(REG_PERIOD, 23);
    random_phase(80, 37);
    // Full table, then lower capacity below the occupancy.
    write_reg(REG_CAPACITY, 16);
    write_reg(REG_PERIOD, 65535);
    idle_pct = 0;
    for (int i = 0; i < ENTRIES; i++) add_req(FUNC_PUT, i, $urandom);
    drain();
    write_reg(REG_CAPACITY, 3);
    write_reg(REG_PERIOD, 4);
    random_phase(40, 57);
    // The sender holds off until every owed answer has come back.
    write_reg(REG_CAPACITY, 8);
    idle_pct = 0;
    for (int i = 0; i < 30; i++) begin
      add_req($urandom_range(1) ? FUNC_GET : FUNC_PUT, pick_key(), pick_value());
      if (i == 15) begin
        while (pending_reqs.size() > 0 || start) @(posedge clk);
        hold_sender = 1'b1;
        while (owed_answers.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
    end
    drain();
    random_phase(60, 0);

    $display("Ran %0d transactions: %0d lookups, %0d of them hits.", n_items, n_gets, n_hits);
    $display("Capacities 0 to 31 and eviction periods 0 to 65535 were used.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lrukv_pkg.sv
rtl/core/lrukv_ctrl.sv
rtl/core/lrukv_dp.sv
rtl/core/lru_key_value_cache.sv
bench/tb_top.sv
